### rtl/core/shb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_pkg: shared types and constants for the H-bridge PWM controller
// Item layouts, register indexes, reset values and the timebase status.
// ----------------------------------------------------------------------------
package shb_pkg;

  localparam int unsigned MaxChannels    = 3;
  localparam int unsigned NumChannelsDef = 3;

  localparam int unsigned CntW   = 16;
  localparam int unsigned SpeedW = 6;
  localparam int unsigned MagW   = SpeedW;
  localparam int unsigned ProdW  = MagW + CntW;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CntW-1:0] ResetPrescale = 16'd800;
  localparam logic [CntW-1:0] ResetTop      = 16'd99;
  localparam logic [CntW-1:0] ResetScale    = 16'd100;
  localparam logic [CntW-1:0] ResetCompare  = 16'd100;

  localparam logic [SpeedW-1:0] SpeedOffset = 6'd32;
  localparam int unsigned       SpeedShift  = 5; // divide by 32

  // item op codes
  localparam logic OpCommand = 1'b0;
  localparam logic OpTick    = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPrescaleDiv = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPeriodTop   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFullScale   = 2'd2;

  typedef struct packed {
    logic       op;
    logic [7:0] command_byte;
  } in_item_t;

  typedef struct packed {
    logic fwd_pin_1;
    logic rev_pin_1;
    logic fwd_pin_2;
    logic rev_pin_2;
    logic fwd_pin_3;
    logic rev_pin_3;
  } out_item_t;

  // timebase status for the step being processed
  typedef struct packed {
    logic            wrap;       // period counter wraps on this step
    logic [CntW-1:0] count_next; // period count after this step
  } tb_t;

endpackage

### rtl/core/shb_timebase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_timebase: prescaler and shared period counter
// Advances on each processed tick item; reports the wrap and next count.
// ----------------------------------------------------------------------------
module shb_timebase (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tick_i,
  input  logic [shb_pkg::CntW-1:0]  prescale_div_i,
  input  logic [shb_pkg::CntW-1:0]  period_top_i,
  output shb_pkg::tb_t              tb_o
);

  logic [shb_pkg::CntW-1:0] presc_q, presc_d;
  logic [shb_pkg::CntW-1:0] period_q, period_d;
  logic                     wrap;

  always_comb begin
    presc_d  = presc_q;
    period_d = period_q;
    wrap     = 1'b0;
    if (tick_i) begin
      if (presc_q >= prescale_div_i) begin
        presc_d = '0;
        if (period_q >= period_top_i) begin
          period_d = '0;
          wrap     = 1'b1;
        end else begin
          period_d = period_q + shb_pkg::CntW'(1);
        end
      end else begin
        presc_d = presc_q + shb_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q  <= '0;
      period_q <= '0;
    end else begin
      presc_q  <= presc_d;
      period_q <= period_d;
    end
  end

  assign tb_o.wrap       = wrap;
  assign tb_o.count_next = period_d;

endmodule

### rtl/core/shb_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_channel: per-channel direction and compare state
// Stages a compare on command, loads it at the period wrap, drives pins.
// ----------------------------------------------------------------------------
module shb_channel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_we_i,
  input  logic                      cmd_fwd_i,
  input  logic [shb_pkg::CntW-1:0]  cmd_compare_i,
  input  shb_pkg::tb_t              tb_i,
  output logic                      fwd_pin_o,
  output logic                      rev_pin_o
);

  logic [shb_pkg::CntW-1:0] pending_q, pending_d;
  logic [shb_pkg::CntW-1:0] active_q, active_d;
  logic                     fwd_q, fwd_d;
  logic                     ref_hi;

  always_comb begin
    pending_d = pending_q;
    fwd_d     = fwd_q;
    active_d  = active_q;
    if (cmd_we_i) begin
      pending_d = cmd_compare_i;
      fwd_d     = cmd_fwd_i;
    end
    // command and tick never share a step, so pending_q is current here
    if (tb_i.wrap) begin
      active_d = pending_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= shb_pkg::ResetCompare;
      active_q  <= shb_pkg::ResetCompare;
      fwd_q     <= 1'b0;
    end else begin
      pending_q <= pending_d;
      active_q  <= active_d;
      fwd_q     <= fwd_d;
    end
  end

  // pin levels reflect the state after this step
  assign ref_hi    = tb_i.count_next < active_d;
  assign fwd_pin_o = fwd_d & ref_hi;
  assign rev_pin_o = ~fwd_d & ~ref_hi;

endmodule

### rtl/core/serial_hbridge_pwm_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_hbridge_pwm_controller: three-channel H-bridge PWM controller
// Takes command bytes and timer ticks; returns all pin levels per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | in_item_i  (op, command_byte)
//  out     | output    | out_valid_o / out_stall_i| out_item_o (six pin levels)
//  cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while out_stall_i is low; each item passes the
// input register, then the result register. The step logic is one 6x16 multiply
// or one counter compare between them. Reset clears counters and directions and
// presets compares. in_stall_o rises only while a result waits and out_stall_i is high.
// ----------------------------------------------------------------------------
module serial_hbridge_pwm_controller #(
  parameter int unsigned NUM_CHANNELS = shb_pkg::NumChannelsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  shb_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output shb_pkg::out_item_t           out_item_o,
  input  logic                         cfg_we_i,
  input  logic [shb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [shb_pkg::CntW-1:0]     cfg_wdata_i
);

  logic [shb_pkg::CntW-1:0] prescale_div_q, period_top_q, full_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_div_q <= shb_pkg::ResetPrescale;
      period_top_q   <= shb_pkg::ResetTop;
      full_scale_q   <= shb_pkg::ResetScale;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        shb_pkg::RegPrescaleDiv: prescale_div_q <= cfg_wdata_i;
        shb_pkg::RegPeriodTop:   period_top_q   <= cfg_wdata_i;
        shb_pkg::RegFullScale:   full_scale_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  logic              s1_valid_q;
  shb_pkg::in_item_t s1_item_q;
  logic              advance;

  assign advance    = s1_valid_q & (~out_valid_o | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_item_i;
    end
  end

  // command decode
  logic                          is_tick, is_cmd;
  logic [1:0]                    cmd_chan;
  logic [shb_pkg::SpeedW-1:0]    low6;
  logic                          cmd_fwd;
  logic [shb_pkg::MagW-1:0]      mag;
  logic [shb_pkg::ProdW-1:0]     prod;
  logic [shb_pkg::CntW-1:0]      cmd_compare;

  assign is_tick  = advance & (s1_item_q.op == shb_pkg::OpTick);
  assign is_cmd   = advance & (s1_item_q.op == shb_pkg::OpCommand);
  assign cmd_chan = s1_item_q.command_byte[7:6];
  assign low6     = s1_item_q.command_byte[shb_pkg::SpeedW-1:0];
  assign cmd_fwd  = low6 > shb_pkg::SpeedOffset;
  assign mag      = cmd_fwd ? (low6 - shb_pkg::SpeedOffset) : low6;
  assign prod     = shb_pkg::ProdW'(mag) * shb_pkg::ProdW'(full_scale_q);
  assign cmd_compare = prod[shb_pkg::SpeedShift +: shb_pkg::CntW];

  shb_pkg::tb_t tb;

  shb_timebase u_timebase (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (is_tick),
    .prescale_div_i (prescale_div_q),
    .period_top_i   (period_top_q),
    .tb_o           (tb)
  );

  logic [shb_pkg::MaxChannels-1:0] fwd_pin, rev_pin;

  for (genvar c = 0; c < shb_pkg::MaxChannels; c++) begin : g_chan
    if (c < NUM_CHANNELS) begin : g_on
      localparam logic [1:0] ChanId = 2'(c + 1);
      shb_channel u_channel (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .cmd_we_i      (is_cmd && (cmd_chan == ChanId)),
        .cmd_fwd_i     (cmd_fwd),
        .cmd_compare_i (cmd_compare),
        .tb_i          (tb),
        .fwd_pin_o     (fwd_pin[c]),
        .rev_pin_o     (rev_pin[c])
      );
    end else begin : g_off
      assign fwd_pin[c] = 1'b0;
      assign rev_pin[c] = 1'b0;
    end
  end

  // result register
  logic               out_valid_q;
  shb_pkg::out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q.fwd_pin_1 <= fwd_pin[0];
      out_item_q.rev_pin_1 <= rev_pin[0];
      out_item_q.fwd_pin_2 <= fwd_pin[1];
      out_item_q.rev_pin_2 <= rev_pin[1];
      out_item_q.fwd_pin_3 <= fwd_pin[2];
      out_item_q.rev_pin_3 <= rev_pin[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### rtl/core/shb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_checker: port-level checks for the H-bridge PWM controller
// Watches handshakes and pin levels; bound to the top level below.
// ----------------------------------------------------------------------------
module shb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input shb_pkg::in_item_t            in_item_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input shb_pkg::out_item_t           out_item_o
);

  // a stalled input item stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("input item changed while stalled");

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // never drive both legs of a bridge
  a_no_shoot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.fwd_pin_1 && out_item_o.rev_pin_1) &&
                    !(out_item_o.fwd_pin_2 && out_item_o.rev_pin_2) &&
                    !(out_item_o.fwd_pin_3 && out_item_o.rev_pin_3))
    else $error("forward and reverse pins both high");

  // input back-pressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // an accepted item reaches the output through the input and result registers if not blocked
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted item did not produce a result");

endmodule

bind serial_hbridge_pwm_controller shb_checker u_shb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for serial_hbridge_pwm_controller
// Sends command bytes and timer ticks with random gaps and output stalls.
// A pin predictor tracks the prescaler, period counter, staged and active
// compares and channel directions, and checks every result item in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NumChannels   = shb_pkg::NumChannelsDef;
  localparam int WatchdogLimit = 4000;
  localparam int HoldOffCycles = 60;

  // Pin predictor and expected-result queue.
  class pwm_scoreboard;
    logic [shb_pkg::CntW-1:0] prescale_div, period_top, full_scale;
    logic [shb_pkg::CntW-1:0] prescale_cnt, period_cnt;
    logic [shb_pkg::CntW-1:0] pending_cmp[shb_pkg::MaxChannels];
    logic [shb_pkg::CntW-1:0] active_cmp[shb_pkg::MaxChannels];
    logic                     forward[shb_pkg::MaxChannels];
    shb_pkg::out_item_t       expected_pins[$];
    int                       errors;
    int                       checked;

    function new();
      prescale_div = shb_pkg::ResetPrescale;
      period_top   = shb_pkg::ResetTop;
      full_scale   = shb_pkg::ResetScale;
      prescale_cnt = '0;
      period_cnt   = '0;
      for (int i = 0; i < shb_pkg::MaxChannels; i++) begin
        pending_cmp[i] = shb_pkg::ResetCompare;
        active_cmp[i]  = shb_pkg::ResetCompare;
        forward[i]     = 1'b0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [shb_pkg::CfgIdxW-1:0] idx,
                          logic [shb_pkg::CntW-1:0] value);
      case (idx)
        shb_pkg::RegPrescaleDiv: prescale_div = value;
        shb_pkg::RegPeriodTop:   period_top = value;
        shb_pkg::RegFullScale:   full_scale = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    function void note_item(shb_pkg::in_item_t it);
      logic [1:0]         chan;
      logic [5:0]         low6;
      logic [5:0]         mag;
      logic               fwd;
      logic [21:0]        prod;
      logic [2:0]         f;
      logic [2:0]         r;
      logic               ref_hi;
      shb_pkg::out_item_t pins;
      if (it.op == shb_pkg::OpCommand) begin
        chan = it.command_byte[7:6];
        low6 = it.command_byte[5:0];
        if (chan != 2'd0 && chan <= NumChannels) begin
          fwd  = low6 > shb_pkg::SpeedOffset;
          mag  = fwd ? low6 - shb_pkg::SpeedOffset : low6;
          prod = mag * full_scale;
          forward[chan - 1]     = fwd;
          pending_cmp[chan - 1] = prod[20:5];
        end
      end else if (prescale_cnt >= prescale_div) begin
        prescale_cnt = '0;
        // staged compares go live only on the period wrap
        if (period_cnt >= period_top) begin
          period_cnt = '0;
          for (int i = 0; i < shb_pkg::MaxChannels; i++)
            active_cmp[i] = pending_cmp[i];
        end else begin
          period_cnt = period_cnt + 1'b1;
        end
      end else begin
        prescale_cnt = prescale_cnt + 1'b1;
      end
      for (int i = 0; i < shb_pkg::MaxChannels; i++) begin
        f[i] = 1'b0;
        r[i] = 1'b0;
        if (i < NumChannels) begin
          ref_hi = period_cnt < active_cmp[i];
          if (forward[i]) f[i] = ref_hi;
          else r[i] = !ref_hi;
        end
      end
      pins.fwd_pin_1 = f[0];
      pins.rev_pin_1 = r[0];
      pins.fwd_pin_2 = f[1];
      pins.rev_pin_2 = r[1];
      pins.fwd_pin_3 = f[2];
      pins.rev_pin_3 = r[2];
      expected_pins.push_back(pins);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at result %0d: %s", checked, what);
      errors++;
    endtask

    task check_pin(string name, logic got, logic want);
      if (got !== want) report_mismatch($sformatf("%s got %b expected %b", name, got, want));
    endtask

    task check_result(shb_pkg::out_item_t got);
      shb_pkg::out_item_t want;
      if (expected_pins.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = expected_pins.pop_front();
        check_pin("fwd_pin_1", got.fwd_pin_1, want.fwd_pin_1);
        check_pin("rev_pin_1", got.rev_pin_1, want.rev_pin_1);
        check_pin("fwd_pin_2", got.fwd_pin_2, want.fwd_pin_2);
        check_pin("rev_pin_2", got.rev_pin_2, want.rev_pin_2);
        check_pin("fwd_pin_3", got.fwd_pin_3, want.fwd_pin_3);
        check_pin("rev_pin_3", got.rev_pin_3, want.rev_pin_3);
      end
      checked++;
    endtask

    task check_drained();
      if (expected_pins.size() != 0)
        report_mismatch($sformatf("%0d expected results never arrived", expected_pins.size()));
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  shb_pkg::in_item_t           in_item_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  shb_pkg::out_item_t          out_item_o;
  logic                        cfg_we_i = 1'b0;
  logic [shb_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [shb_pkg::CntW-1:0]    cfg_wdata_i = '0;

  pwm_scoreboard sb;
  int items_sent_ok;
  int quiet_cycles;
  int send_idle_pct;
  int stall_pct;
  int hold_left;
  bit hold_off_req;

  serial_hbridge_pwm_controller uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Accept monitor, checker and watchdog.
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_item(in_item_i);
        items_sent_ok++;
      end
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic shb_pkg::in_item_t make_cmd(logic [1:0] chan, logic [5:0] low6);
    shb_pkg::in_item_t it;
    it.op = shb_pkg::OpCommand;
    it.command_byte = {chan, low6};
    return it;
  endfunction

  function automatic shb_pkg::in_item_t tick_item();
    shb_pkg::in_item_t it;
    it.op = shb_pkg::OpTick;
    it.command_byte = 8'($urandom);
    return it;
  endfunction

  function automatic shb_pkg::in_item_t random_item();
    shb_pkg::in_item_t it;
    it = tick_item();
    if ($urandom_range(99) < 20) begin
      it.op = shb_pkg::OpCommand;
      // lean on the direction boundary and the speed extremes
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(4))
          0: it.command_byte[5:0] = 6'd0;
          1: it.command_byte[5:0] = 6'd31;
          2: it.command_byte[5:0] = 6'd32;
          3: it.command_byte[5:0] = 6'd33;
          default: it.command_byte[5:0] = 6'd63;
        endcase
      end
    end
    return it;
  endfunction

  // Entered and left just after a falling edge; valid stays high on return.
  task automatic send_item(shb_pkg::in_item_t it);
    int target;
    target = items_sent_ok + 1;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(negedge clk); while (items_sent_ok < target);
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_config(logic [shb_pkg::CntW-1:0] div,
                              logic [shb_pkg::CntW-1:0] top,
                              logic [shb_pkg::CntW-1:0] scale);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= shb_pkg::RegPrescaleDiv;
    cfg_wdata_i <= div;
    @(negedge clk);
    sb.set_reg(shb_pkg::RegPrescaleDiv, div);
    cfg_idx_i   <= shb_pkg::RegPeriodTop;
    cfg_wdata_i <= top;
    @(negedge clk);
    sb.set_reg(shb_pkg::RegPeriodTop, top);
    cfg_idx_i   <= shb_pkg::RegFullScale;
    cfg_wdata_i <= scale;
    @(negedge clk);
    sb.set_reg(shb_pkg::RegFullScale, scale);
    cfg_we_i <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(logic [shb_pkg::CntW-1:0] div,
                           logic [shb_pkg::CntW-1:0] top,
                           logic [shb_pkg::CntW-1:0] scale, int idle_pct, int stall,
                           int n_items, bit pressure);
    drain_block();
    write_config(div, top, scale);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    if (pressure) hold_off_req = 1'b1;
    repeat (n_items) send_item(random_item());
  endtask

  initial begin
    sb = new();
    items_sent_ok = 0;
    quiet_cycles  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    hold_off_req  = 1'b0;
    repeat (12) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // Reset settings: channel zero ignored, full forward, zero and full reverse.
    send_item(tick_item());
    send_item(tick_item());
    send_item(make_cmd(2'd0, 6'd63));
    send_item(make_cmd(2'd0, 6'd0));
    send_item(make_cmd(2'd1, 6'd63));
    send_item(make_cmd(2'd2, 6'd0));
    send_item(make_cmd(2'd3, 6'd32));
    send_item(tick_item());
    send_item(tick_item());

    // Period top zero with the largest scale: wrap and reload on every tick.
    drain_block();
    write_config(16'd0, 16'd0, 16'hFFFF);
    send_item(make_cmd(2'd1, 6'd33));
    send_item(make_cmd(2'd2, 6'd31));
    send_item(make_cmd(2'd3, 6'd63));
    send_item(tick_item());
    send_item(tick_item());
    send_item(tick_item());

    // Run the period count up, then lower the top below it.
    drain_block();
    write_config(16'd0, 16'd20, 16'd100);
    repeat (10) send_item(tick_item());
    drain_block();
    write_config(16'd0, 16'd4, 16'd100);
    send_item(tick_item());
    send_item(tick_item());

    run_phase(16'd0,     16'd7,     16'd8,     0,  0,  250, 1'b1);
    run_phase(16'd1,     16'd15,    16'd16,    47, 0,  250, 1'b0);
    run_phase(16'd3,     16'd2,     16'hFFFF,  0,  47, 250, 1'b0);
    run_phase(16'd0,     16'd0,     16'd1,     23, 23, 200, 1'b0);
    run_phase(16'hFFFF,  16'hFFFF,  16'd50,    0,  0,  100, 1'b0);
    run_phase(16'd2,     16'd3,     16'd4,     47, 0,  250, 1'b0);
    run_phase(16'd0,     16'd63,    16'd40000, 0,  47, 250, 1'b0);
    run_phase(16'd1,     16'd5,     16'd7,     23, 23, 250, 1'b0);

    drain_block();
    repeat (8) @(negedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/shb_pkg.sv
rtl/core/shb_timebase.sv
rtl/core/shb_channel.sv
rtl/core/serial_hbridge_pwm_controller.sv
rtl/core/shb_checker.sv
tb/sv/testbench.sv
